### rtl/sha_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_e;

  // Front part: collecting, padded block owed, length-only block owed.
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PAD,
    PEND_LEN
  } pend_state_e;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k;
    begin
      unique case (t)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  // Block request from the front part to the compression core.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_req_t;

endpackage

### rtl/sha_front.sv
// Front part: collects bytes into a 64-byte block, adds padding and length.
// Depends on sha_pkg.
module sha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sha_pkg::in_item_t   in_i,
  output logic                blk_valid_o,
  input  logic                blk_ready_i,
  output sha_pkg::blk_req_t   blk_o
);

  logic [511:0] buf_q, buf_d;
  logic [60:0]  cnt_q, cnt_d;
  sha_pkg::pend_state_e pend_q, pend_d;
  logic         bv_q, bv_d;
  sha_pkg::blk_req_t breq_q, breq_d;

  logic [5:0]   pos;
  logic [60:0]  cnt_inc;
  logic [511:0] wbuf;
  logic [511:0] padded;
  logic [63:0]  bits;
  logic         acc;

  assign ready_o     = (pend_q == sha_pkg::PEND_NONE) && !bv_q;
  assign acc         = valid_i && ready_o;
  assign blk_valid_o = bv_q;
  assign blk_o       = breq_q;

  always_comb begin
    pos     = cnt_q[5:0];
    cnt_inc = cnt_q + 61'd1;
    wbuf    = buf_q;
    wbuf[511 - {pos, 3'b000} -: 8] = in_i.data_byte;
  end

  // Pad the buffer at the current count: 0x80 at pos, zeros after.
  always_comb begin
    bits   = {cnt_q, 3'b000};
    padded = buf_q;
    for (int i = 0; i < 64; i++) begin
      if (i[5:0] == cnt_q[5:0]) padded[511 - 8*i -: 8] = sha_pkg::PadByte;
      else if (i[5:0] > cnt_q[5:0]) padded[511 - 8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    pend_d = pend_q;
    unique case (pend_q)
      sha_pkg::PEND_NONE: if (acc && in_i.end_of_message) pend_d = sha_pkg::PEND_PAD;
      sha_pkg::PEND_PAD: begin
        if (!bv_q) pend_d = (cnt_q[5:0] > 6'd55) ? sha_pkg::PEND_LEN : sha_pkg::PEND_NONE;
      end
      sha_pkg::PEND_LEN: if (!bv_q) pend_d = sha_pkg::PEND_NONE;
      default:           pend_d = sha_pkg::PEND_NONE;
    endcase
  end

  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    bv_d   = bv_q;
    breq_d = breq_q;
    if (bv_q && blk_ready_i) bv_d = 1'b0;
    if (acc) begin
      if (in_i.has_byte) begin
        buf_d = wbuf;
        cnt_d = cnt_inc;
        if (pos == 6'd63) begin
          bv_d   = 1'b1;
          breq_d = '{block: wbuf, final_blk: 1'b0};
        end
      end
    end else if (!bv_q && pend_q == sha_pkg::PEND_PAD) begin
      bv_d = 1'b1;
      if (cnt_q[5:0] > 6'd55) begin
        breq_d = '{block: padded, final_blk: 1'b0};
      end else begin
        breq_d = '{block: {padded[511:64], bits}, final_blk: 1'b1};
        cnt_d  = '0;
      end
    end else if (!bv_q && pend_q == sha_pkg::PEND_LEN) begin
      bv_d   = 1'b1;
      breq_d = '{block: {448'd0, bits}, final_blk: 1'b1};
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= sha_pkg::PEND_NONE;
      bv_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      bv_q   <= bv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    breq_q <= breq_d;
  end

endmodule

### rtl/sha_core.sv
// Back part: 64-round compression, one round per cycle, and digest output.
// Depends on sha_pkg.
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                blk_valid_i,
  output logic                blk_ready_o,
  input  sha_pkg::blk_req_t   blk_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sha_pkg::out_item_t  out_o
);

  sha_pkg::core_state_e state_q, state_d;
  logic [255:0] hv_q, hv_d;
  logic [255:0] v_q, v_d;
  logic [511:0] w_q, w_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic         fin_q, fin_d;

  logic [31:0] a, b, c, d, e, f, g, h, w0, s0, s1, t1, t2, wn;
  logic [31:0] x, y;

  assign blk_ready_o = (state_q == sha_pkg::ST_IDLE);

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_q;
    w0 = w_q[511:480];
    x  = w_q[479:448];
    y  = w_q[63:32];
    s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
    wn = w0 + s0 + w_q[223:192] + s1;
    t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + sha_pkg::round_const(rnd_q) + w0;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha_pkg::ST_IDLE:  if (blk_valid_i) state_d = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD:   state_d = fin_q ? sha_pkg::ST_EMIT : sha_pkg::ST_IDLE;
      sha_pkg::ST_EMIT:  if (ready_i && idx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
      default:           state_d = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    hv_d  = hv_q;
    v_d   = v_q;
    w_d   = w_q;
    rnd_d = rnd_q;
    idx_d = idx_q;
    fin_d = fin_q;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (blk_valid_i) begin
          v_d   = hv_q;
          w_d   = blk_i.block;
          fin_d = blk_i.final_blk;
          rnd_d = '0;
        end
      end
      sha_pkg::ST_ROUND: begin
        v_d   = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_d   = {w_q[479:0], wn};
        rnd_d = rnd_q + 6'd1;
      end
      sha_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) hv_d[32*i +: 32] = hv_q[32*i +: 32] + v_q[32*i +: 32];
        idx_d = '0;
      end
      sha_pkg::ST_EMIT: begin
        if (ready_i) begin
          idx_d = idx_q + 3'd1;
          // Reinitialize after the last word for the next message.
          if (idx_q == 3'd7) hv_d = sha_pkg::InitHash;
        end
      end
      default: ;
    endcase
  end

  assign valid_o = (state_q == sha_pkg::ST_EMIT);
  assign out_o.digest_word = hv_q[255 - {idx_q, 5'b00000} -: 32];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      hv_q    <= sha_pkg::InitHash;
      rnd_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hv_q    <= hv_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

endmodule

### rtl/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher: front collector, block request
// register, compression core. Depends on sha_pkg, sha_front, sha_core.
//
//  channel | signals                    | moves
//  --------+----------------------------+------------------------------
//  input   | in_valid_i/in_ready_o/in_i | one byte/end flag per request
//  output  | out_valid_o/out_ready_i/.. | one digest word per request
//
// Bytes are taken one per cycle while no block request or end of message
// is pending; a full block is taken by the core when it is idle, then 64
// rounds and one add step follow.
// End of message adds one or two padded blocks, each handed to the core
// as it goes idle; eight digest words follow, one per cycle unless stalled.
// Reset restores the initial hash and clears the byte count.
// The output stalls only the core; the front waits while it holds a block
// request that the busy core has not yet taken.
module sha256_byte_stream_hasher_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_o
);

  logic              blk_valid;
  logic              blk_ready;
  sha_pkg::blk_req_t blk;

  sha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .in_i        (in_i),
    .blk_valid_o (blk_valid),
    .blk_ready_i (blk_ready),
    .blk_o       (blk)
  );

  sha_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_ready_o (blk_ready),
    .blk_i       (blk),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .out_o       (out_o)
  );

endmodule
